// ===== sv/pad_pkg.sv =====
// Shared types, constants and tables of the powerset speaker decoder.
// Used by the channel interfaces and by every module of the block.
package pad_pkg;

  localparam int MaxSpeakers  = 8;
  localparam int ScoreWidth   = 16;
  localparam int MaskWidth    = MaxSpeakers;
  localparam int IndexWidth   = 8;
  localparam int CountWidth   = 9;
  localparam int SpkWidth     = 4;
  localparam int CfgWidth     = 9;
  localparam int CfgIdxWidth  = 2;
  localparam int LaneSelWidth = $clog2(MaxSpeakers);

  typedef logic [MaskWidth-1:0]         mask_t;
  typedef logic signed [ScoreWidth-1:0] score_t;
  typedef logic [IndexWidth-1:0]        index_t;
  typedef logic [CountWidth-1:0]        count_t;
  typedef logic [SpkWidth-1:0]          spk_t;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusCountErr = 2'd1,
    StatusCfgErr   = 2'd2
  } status_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgNumSpeakers     = 2'd0,
    CfgMaxOverlap      = 2'd1,
    CfgExpectedClasses = 2'd2
  } cfg_reg_e;

  // Running argmax state as seen by the current item.
  typedef struct packed {
    logic   take;        // current score becomes the new maximum
    index_t best_index;  // argmax including the current score
    count_t count;       // score count including the current score
  } argmax_t;

  typedef struct packed {
    mask_t   speaker_mask;
    index_t  best_class;
    status_e frame_status;
  } result_t;

  // Number of classes for n speakers and at most k active at once:
  // 1 + sum of C(n, j) for j = 1..k. Row n, column k; zero where k > n and in row 0.
  localparam count_t ClassTotal [MaxSpeakers+1][MaxSpeakers+1] = '{
    '{9'd0, 9'd0, 9'd0,  9'd0,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
    '{9'd1, 9'd2, 9'd0,  9'd0,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
    '{9'd1, 9'd3, 9'd4,  9'd0,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
    '{9'd1, 9'd4, 9'd7,  9'd8,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
    '{9'd1, 9'd5, 9'd11, 9'd15, 9'd16,  9'd0,   9'd0,   9'd0,   9'd0},
    '{9'd1, 9'd6, 9'd16, 9'd26, 9'd31,  9'd32,  9'd0,   9'd0,   9'd0},
    '{9'd1, 9'd7, 9'd22, 9'd42, 9'd57,  9'd63,  9'd64,  9'd0,   9'd0},
    '{9'd1, 9'd8, 9'd29, 9'd64, 9'd99,  9'd120, 9'd127, 9'd128, 9'd0},
    '{9'd1, 9'd9, 9'd37, 9'd93, 9'd163, 9'd219, 9'd247, 9'd255, 9'd256}
  };

endpackage

// ===== sv/pad_in_if.sv =====
// Score input channel: valid/ready handshake with one class score per item.
// Depends on pad_pkg.
interface pad_in_if import pad_pkg::*; ();

  logic   valid;
  logic   ready;
  score_t score;
  logic   last_in_frame;

  modport source (output valid, output score, output last_in_frame, input ready);
  modport sink   (input valid, input score, input last_in_frame, output ready);

endinterface

// ===== sv/pad_out_if.sv =====
// Result output channel: valid/ready handshake with one decoded frame per item.
// Depends on pad_pkg.
interface pad_out_if import pad_pkg::*; ();

  logic         valid;
  logic         ready;
  mask_t        speaker_mask;
  index_t       best_class;
  logic [1:0]   frame_status;

  modport source (output valid, output speaker_mask, output best_class,
                  output frame_status, input ready);
  modport sink   (input valid, input speaker_mask, input best_class,
                  input frame_status, output ready);

endinterface

// ===== sv/pad_argmax.sv =====
// Running maximum, its index and the saturating score count of one frame.
// Depends on pad_pkg.
module pad_argmax import pad_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  logic    last_i,
  input  score_t  score_i,
  output argmax_t st_o
);

  score_t best_score_q;
  index_t best_index_q;
  count_t count_q;
  logic   in_range;
  logic   take;
  count_t count_d;

  // Only the first 256 scores of a frame take part in the compare.
  assign in_range = ~count_q[CountWidth-1];
  assign take     = in_range && ((count_q == '0) || (score_i > best_score_q));
  assign count_d  = (count_q == '1) ? count_q : count_q + count_t'(1);

  assign st_o.take       = take;
  assign st_o.best_index = take ? count_q[IndexWidth-1:0] : best_index_q;
  assign st_o.count      = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q <= '0;
      best_index_q <= '0;
      count_q      <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        best_score_q <= '0;
        best_index_q <= '0;
        count_q      <= '0;
      end else begin
        count_q <= count_d;
        if (take) begin
          best_score_q <= score_i;
          best_index_q <= count_q[IndexWidth-1:0];
        end
      end
    end
  end

endmodule

// ===== sv/pad_mask_lanes.sv =====
// Per speaker-count lanes that step through the class sets in class order
// and keep the set of the current maximum. Depends on pad_pkg.
module pad_mask_lanes import pad_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  logic                    take_i,
  input  logic                    frame_end_i,
  input  logic [LaneSelWidth-1:0] lane_sel_i,
  output mask_t                   mask_o
);

  mask_t cur_q  [MaxSpeakers];
  mask_t best_q [MaxSpeakers];
  mask_t cur_d  [MaxSpeakers];

  // Next subset in class order over n speakers: raise the highest member that
  // can move up, pack the members above it right behind it; when none can
  // move, start the first subset of the next size.
  function automatic mask_t next_subset(mask_t m, int n);
    mask_t nxt;
    logic  found;
    int    x;
    int    t;
    int    k;
    found = 1'b0;
    x     = 0;
    t     = 0;
    k     = 0;
    nxt   = '0;
    for (int i = 0; i < MaskWidth - 1; i++) begin
      if ((i < n - 1) && m[i] && !m[i+1]) begin
        found = 1'b1;
        x     = i;
      end
    end
    for (int i = 0; i < MaskWidth; i++) begin
      if (m[i]) begin
        k = k + 1;
        if (i > x) t = t + 1;
      end
    end
    for (int i = 0; i < MaskWidth; i++) begin
      if (found) nxt[i] = (i < x) ? m[i] : ((i > x) && (i <= x + 1 + t));
      else       nxt[i] = (i < k + 1);
    end
    return nxt;
  endfunction

  always_comb begin
    for (int l = 0; l < MaxSpeakers; l++) begin
      cur_d[l] = next_subset(cur_q[l], l + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < MaxSpeakers; l++) begin
        cur_q[l]  <= '0;
        best_q[l] <= '0;
      end
    end else if (advance_i) begin
      for (int l = 0; l < MaxSpeakers; l++) begin
        if (frame_end_i) begin
          cur_q[l]  <= '0;
          best_q[l] <= '0;
        end else begin
          cur_q[l] <= cur_d[l];
          if (take_i) best_q[l] <= cur_q[l];
        end
      end
    end
  end

  assign mask_o = take_i ? cur_q[lane_sel_i] : best_q[lane_sel_i];

endmodule

// ===== sv/pad_out_buf.sv =====
// Two-entry result buffer: an output register plus a skid entry.
// Depends on pad_pkg and pad_out_if.
module pad_out_buf import pad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  result_t   push_data_i,
  output logic      space_o,
  pad_out_if.source out_o
);

  result_t head_q;
  result_t skid_q;
  logic    head_vld_q;
  logic    skid_vld_q;
  logic    pop;

  assign pop     = head_vld_q && out_o.ready;
  assign space_o = ~skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!head_vld_q) begin
        head_vld_q <= push_i;
      end else if (pop) begin
        if (skid_vld_q) begin
          skid_vld_q <= 1'b0;
        end else begin
          head_vld_q <= push_i;
        end
      end else if (push_i) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!head_vld_q || pop) begin
      if (head_vld_q && skid_vld_q) head_q <= skid_q;
      else if (push_i)              head_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign out_o.valid        = head_vld_q;
  assign out_o.speaker_mask = head_q.speaker_mask;
  assign out_o.best_class   = head_q.best_class;
  assign out_o.frame_status = head_q.frame_status;

endmodule

// ===== sv/powerset_argmax_speaker_decode_core.sv =====
// Powerset speaker decoder: streaming argmax over one frame of class scores.
// Throughput: one score item per cycle, set by the running compare, while the result buffer has space.
// The result of a frame goes into the output register, or into the skid entry while the output is stalled.
// Two result entries buffer a stalled output; input stalls only when both are full.
// Reset clears the frame state and loads a speaker count of 3, max_overlap 2,
// expected_classes 0.
module powerset_argmax_speaker_decode_core import pad_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  pad_in_if.sink                 in_i,
  pad_out_if.source              out_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i
);

  // Configuration registers. They are sampled only when a frame ends.
  spk_t   spk_count_q;
  spk_t   max_overlap_q;
  count_t expected_classes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spk_count_q        <= spk_t'(3);
      max_overlap_q      <= spk_t'(2);
      expected_classes_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgNumSpeakers:     spk_count_q        <= cfg_data_i[SpkWidth-1:0];
        CfgMaxOverlap:      max_overlap_q      <= cfg_data_i[SpkWidth-1:0];
        CfgExpectedClasses: expected_classes_q <= cfg_data_i[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake. The buffer keeps a free slot whenever ready is high,
  // so a frame-ending item can always be stored.
  logic    in_acc;
  logic    buf_space;
  logic    frame_end;
  argmax_t am_st;
  mask_t   lane_mask;

  assign in_i.ready = buf_space;
  assign in_acc     = in_i.valid && buf_space;
  assign frame_end  = in_acc && in_i.last_in_frame;

  pad_argmax u_argmax (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .last_i   (in_i.last_in_frame),
    .score_i  (in_i.score),
    .st_o     (am_st)
  );

  // One lane per possible speaker count tracks the speaker set of each class
  // index as it streams by, so no unranking is needed at the end of a frame.
  // Within the valid class range the order does not depend on max_overlap.
  logic [LaneSelWidth-1:0] lane_sel;
  assign lane_sel = LaneSelWidth'(spk_count_q - spk_t'(1));

  pad_mask_lanes u_lanes (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (in_acc),
    .take_i      (am_st.take),
    .frame_end_i (in_i.last_in_frame),
    .lane_sel_i  (lane_sel),
    .mask_o      (lane_mask)
  );

  // Frame status: a bad configuration wins over a count mismatch.
  logic    shape_ok;
  logic    cfg_ok;
  count_t  class_total;
  result_t result;

  assign shape_ok = (spk_count_q != '0) && (spk_count_q <= spk_t'(MaxSpeakers)) &&
                    (max_overlap_q <= spk_count_q);

  always_comb begin
    class_total = '0;
    if (shape_ok) class_total = ClassTotal[spk_count_q][max_overlap_q];
  end

  assign cfg_ok = shape_ok &&
                  ((expected_classes_q == '0) || (expected_classes_q == class_total));

  always_comb begin
    result.best_class   = am_st.best_index;
    result.speaker_mask = '0;
    if (!cfg_ok) begin
      result.frame_status = StatusCfgErr;
    end else if (am_st.count != class_total) begin
      result.frame_status = StatusCountErr;
    end else begin
      result.frame_status = StatusOk;
      result.speaker_mask = lane_mask;
    end
  end

  pad_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (frame_end),
    .push_data_i (result),
    .space_o     (buf_space),
    .out_o       (out_o)
  );

  // A clean frame never names a speaker beyond the configured count.
  a_mask_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.frame_status == StatusOk)) |->
      ((out_o.speaker_mask >> spk_count_q) == '0))
    else $error("speaker mask names a speaker beyond the speaker count");

  // A clean frame never has more simultaneous speakers than max_overlap.
  a_mask_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.frame_status == StatusOk)) |->
      ($countones(out_o.speaker_mask) <= max_overlap_q))
    else $error("speaker mask exceeds max_overlap");

  // Only class 0 maps to the empty set, and errors report no speakers.
  a_mask_vs_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      ((out_o.frame_status == StatusOk) ?
        ((out_o.best_class == '0) == (out_o.speaker_mask == '0)) :
        (out_o.speaker_mask == '0)))
    else $error("speaker mask inconsistent with class or status");

  // After a frame ends, the next score is counted as the first of a new frame.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> (am_st.count == count_t'(1)))
    else $error("frame state not cleared at frame end");

endmodule
